// ===== rtl/weighted_sum_tree_sampler_core_assert.svh =====
// Assertion macros used by the sampler's top level.
`ifndef WEIGHTED_SUM_TREE_SAMPLER_CORE_ASSERT_SVH
`define WEIGHTED_SUM_TREE_SAMPLER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSTS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wsts_pkg.sv =====
// Types, codes and constants of the weighted sum-tree sampler.
package wsts_pkg;

    localparam int LEAVES_DEF = 256;
    localparam int ID_W       = 8;
    localparam int WT_W       = 24;
    localparam int DRAW_W     = 48;
    localparam int SUM_W      = 32;
    localparam int RATE_W     = 16;
    localparam int PROD_W     = SUM_W + RATE_W;
    localparam int ID_COUNT   = 256;
    localparam int IN_W       = 80;
    localparam int OUT_W      = 56;
    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;

    localparam logic [RATE_W-1:0]  RATE_RESET     = 16'd256;
    localparam logic [PADDR_W-1:0] ADDR_BASE_RATE = 2'd0;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_REMOVE = 2'd1,
        K_UPDATE = 2'd2,
        K_SELECT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_ABSENT = 3'd1,
        ST_FULL   = 3'd2,
        ST_DUP    = 3'd3,
        ST_EMPTY  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PATH_ERR,
        PATH_INS,
        PATH_UPD,
        PATH_SEL
    } path_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_INS_RD,
        S_INS_WR,
        S_INS_FIN,
        S_UP_OLD,
        S_UP_RD,
        S_UP_WR,
        S_UP_FIN,
        S_SEL_RD,
        S_SEL_MUL,
        S_SEL_CMP,
        S_SEL_FIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic decide;
        logic ins_rd;
        logic ins_wr;
        logic ins_fin;
        logic up_old;
        logic up_rd;
        logic up_wr;
        logic up_fin;
        logic sel_rd;
        logic sel_mul;
        logic sel_cmp;
        logic sel_fin;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic  clr_last;
        logic  at_leaf;
        logic  at_root;
        path_t path;
    } sts_t;

endpackage

// ===== rtl/wsts_ctrl.sv =====
// Operation sequencer of the sampler: walks the tree one level at a time.
module wsts_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic            m_tvalid,
    input  logic            m_tready,
    input  wsts_pkg::sts_t  sts,
    output wsts_pkg::cmd_t  cmd
);

    wsts_pkg::state_t state_reg;
    wsts_pkg::state_t state_next;
    logic             out_free;

    assign out_free = !m_tvalid || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsts_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wsts_pkg::S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = wsts_pkg::S_IDLE;
                end
            end
            wsts_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = wsts_pkg::S_DECIDE;
                end
            end
            wsts_pkg::S_DECIDE:
            begin
                case (sts.path)
                    wsts_pkg::PATH_INS: state_next = wsts_pkg::S_INS_RD;
                    wsts_pkg::PATH_UPD: state_next = wsts_pkg::S_UP_OLD;
                    wsts_pkg::PATH_SEL: state_next = wsts_pkg::S_SEL_RD;
                    default:            state_next = wsts_pkg::S_DONE;
                endcase
            end
            wsts_pkg::S_INS_RD:
            begin
                state_next = sts.at_leaf ? wsts_pkg::S_INS_FIN : wsts_pkg::S_INS_WR;
            end
            wsts_pkg::S_INS_WR:  state_next = wsts_pkg::S_INS_RD;
            wsts_pkg::S_INS_FIN: state_next = wsts_pkg::S_DONE;
            wsts_pkg::S_UP_OLD:  state_next = wsts_pkg::S_UP_RD;
            wsts_pkg::S_UP_RD:
            begin
                state_next = sts.at_root ? wsts_pkg::S_UP_FIN : wsts_pkg::S_UP_WR;
            end
            wsts_pkg::S_UP_WR:   state_next = wsts_pkg::S_UP_RD;
            wsts_pkg::S_UP_FIN:  state_next = wsts_pkg::S_DONE;
            wsts_pkg::S_SEL_RD:
            begin
                state_next = sts.at_leaf ? wsts_pkg::S_SEL_FIN : wsts_pkg::S_SEL_MUL;
            end
            wsts_pkg::S_SEL_MUL: state_next = wsts_pkg::S_SEL_CMP;
            wsts_pkg::S_SEL_CMP: state_next = wsts_pkg::S_SEL_RD;
            wsts_pkg::S_SEL_FIN: state_next = wsts_pkg::S_DONE;
            wsts_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = wsts_pkg::S_IDLE;
                end
            end
            default: state_next = wsts_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            wsts_pkg::S_CLEAR:   cmd.clr_step = 1'b1;
            wsts_pkg::S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            wsts_pkg::S_DECIDE:  cmd.decide  = 1'b1;
            wsts_pkg::S_INS_RD:  cmd.ins_rd  = 1'b1;
            wsts_pkg::S_INS_WR:  cmd.ins_wr  = 1'b1;
            wsts_pkg::S_INS_FIN: cmd.ins_fin = 1'b1;
            wsts_pkg::S_UP_OLD:  cmd.up_old  = 1'b1;
            wsts_pkg::S_UP_RD:   cmd.up_rd   = 1'b1;
            wsts_pkg::S_UP_WR:   cmd.up_wr   = 1'b1;
            wsts_pkg::S_UP_FIN:  cmd.up_fin  = 1'b1;
            wsts_pkg::S_SEL_RD:  cmd.sel_rd  = 1'b1;
            wsts_pkg::S_SEL_MUL: cmd.sel_mul = 1'b1;
            wsts_pkg::S_SEL_CMP: cmd.sel_cmp = 1'b1;
            wsts_pkg::S_SEL_FIN: cmd.sel_fin = 1'b1;
            wsts_pkg::S_DONE:    cmd.out_load = out_free;
            default:             cmd = '0;
        endcase
    end

endmodule

// ===== rtl/wsts_dp.sv =====
// Datapath of the sampler: tree memories, walk registers, result and config registers.
module wsts_dp #(
    parameter int LEAVES = wsts_pkg::LEAVES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [wsts_pkg::IN_W-1:0]     s_tdata,
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wsts_pkg::OUT_W-1:0]    m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsts_pkg::PADDR_W-1:0]  paddr,
    input  logic [wsts_pkg::PDATA_W-1:0]  pwdata,
    output logic [wsts_pkg::PDATA_W-1:0]  prdata,
    input  wsts_pkg::cmd_t                cmd,
    output wsts_pkg::sts_t                sts
);

    localparam int LVL = $clog2(LEAVES);
    localparam int NW  = LVL + 1;
    localparam int CW  = LVL + 1;

    // Internal nodes 1..LEAVES-1: left weight sum and both subtree counts.
    logic [wsts_pkg::SUM_W-1:0] tsum_mem [LEAVES];
    logic [LVL-1:0]             tlc_mem  [LEAVES];
    logic [LVL-1:0]             trc_mem  [LEAVES];
    logic [wsts_pkg::WT_W-1:0]  wleaf_mem [LEAVES];
    logic                       ovalid_mem [LEAVES];
    logic [wsts_pkg::ID_W-1:0]  oid_mem  [LEAVES];
    logic [LVL-1:0]             eleaf_mem [wsts_pkg::ID_COUNT];
    logic [wsts_pkg::ID_COUNT-1:0] evalid_reg;

    wsts_pkg::kind_t              kind_reg;
    logic [wsts_pkg::ID_W-1:0]    id_reg;
    logic [wsts_pkg::WT_W-1:0]    w_reg;
    logic [wsts_pkg::DRAW_W-1:0]  draw_reg;
    logic [NW-1:0]                node_reg;
    logic [LVL-1:0]               leaf_reg;
    logic [wsts_pkg::WT_W-1:0]    old_reg;
    logic [wsts_pkg::PROD_W-1:0]  prod_reg;
    logic [LVL-1:0]               clr_idx_reg;
    logic [wsts_pkg::SUM_W-1:0]   total_reg;
    logic [CW-1:0]                count_reg;
    logic [wsts_pkg::RATE_W-1:0]  rate_reg;

    logic [wsts_pkg::SUM_W-1:0]   tq_sum;
    logic [LVL-1:0]               tq_lc;
    logic [LVL-1:0]               tq_rc;
    logic [wsts_pkg::WT_W-1:0]    wq;
    logic                         oq_valid;
    logic [wsts_pkg::ID_W-1:0]    oq_id;
    logic [LVL-1:0]               eq_leaf;

    wsts_pkg::status_t            res_status_reg;
    logic [wsts_pkg::ID_W-1:0]    res_id_reg;
    logic [LVL-1:0]               res_leaf_reg;
    logic                         m_tvalid_reg;
    logic [wsts_pkg::OUT_W-1:0]   m_tdata_reg;

    logic [LVL-1:0]               nidx;
    logic [LVL-1:0]               pidx;
    logic                         is_remove;
    logic                         id_valid;
    logic                         tree_full;
    logic                         tree_empty;
    logic [wsts_pkg::SUM_W-1:0]   new_w;
    logic [wsts_pkg::SUM_W-1:0]   old_w;
    logic                         cfg_wr;

    assign nidx       = node_reg[LVL-1:0];
    assign pidx       = node_reg[LVL:1];
    assign is_remove  = (kind_reg == wsts_pkg::K_REMOVE);
    assign id_valid   = evalid_reg[id_reg];
    assign tree_full  = (count_reg == CW'(LEAVES));
    assign tree_empty = (count_reg == '0);
    assign old_w      = wsts_pkg::SUM_W'(old_reg);
    assign new_w      = is_remove ? '0 : wsts_pkg::SUM_W'(w_reg);
    assign cfg_wr     = psel && penable && pwrite && (paddr == wsts_pkg::ADDR_BASE_RATE);

    always_comb
    begin
        sts.clr_last = (clr_idx_reg == {LVL{1'b1}});
        sts.at_leaf  = node_reg[LVL];
        sts.at_root  = (node_reg == NW'(1));
        case (kind_reg)
            wsts_pkg::K_INSERT:
                sts.path = (id_valid || tree_full) ? wsts_pkg::PATH_ERR : wsts_pkg::PATH_INS;
            wsts_pkg::K_REMOVE,
            wsts_pkg::K_UPDATE:
                sts.path = id_valid ? wsts_pkg::PATH_UPD : wsts_pkg::PATH_ERR;
            wsts_pkg::K_SELECT:
                sts.path = tree_empty ? wsts_pkg::PATH_ERR : wsts_pkg::PATH_SEL;
            default:
                sts.path = wsts_pkg::PATH_ERR;
        endcase
    end

    // Node memory: one read port and one write port.
    always_ff @(posedge clk)
    begin
        if (cmd.ins_rd || cmd.sel_rd || cmd.up_rd)
        begin
            tq_sum <= tsum_mem[cmd.up_rd ? pidx : nidx];
            tq_lc  <= tlc_mem[cmd.up_rd ? pidx : nidx];
            tq_rc  <= trc_mem[cmd.up_rd ? pidx : nidx];
        end
        if (cmd.clr_step)
        begin
            tsum_mem[clr_idx_reg] <= '0;
            tlc_mem[clr_idx_reg]  <= '0;
            trc_mem[clr_idx_reg]  <= '0;
        end
        else if (cmd.ins_wr)
        begin
            if (tq_lc <= tq_rc)
            begin
                tsum_mem[nidx] <= tq_sum + wsts_pkg::SUM_W'(w_reg);
                tlc_mem[nidx]  <= tq_lc + LVL'(1);
            end
            else
            begin
                trc_mem[nidx] <= tq_rc + LVL'(1);
            end
        end
        else if (cmd.up_wr)
        begin
            if (!node_reg[0])
            begin
                tsum_mem[pidx] <= tq_sum - old_w + new_w;
                if (is_remove)
                begin
                    tlc_mem[pidx] <= tq_lc - LVL'(1);
                end
            end
            else if (is_remove)
            begin
                trc_mem[pidx] <= tq_rc - LVL'(1);
            end
        end
    end

    // Leaf weight memory.
    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            wq <= wleaf_mem[eq_leaf];
        end
        if (cmd.ins_fin)
        begin
            wleaf_mem[nidx] <= w_reg;
        end
        else if (cmd.up_old)
        begin
            wleaf_mem[leaf_reg] <= is_remove ? '0 : w_reg;
        end
    end

    // Leaf owner memory, swept empty after reset.
    always_ff @(posedge clk)
    begin
        if (cmd.sel_rd)
        begin
            oq_valid <= ovalid_mem[nidx];
            oq_id    <= oid_mem[nidx];
        end
        if (cmd.clr_step)
        begin
            ovalid_mem[clr_idx_reg] <= 1'b0;
            oid_mem[clr_idx_reg]    <= '0;
        end
        else if (cmd.ins_fin)
        begin
            ovalid_mem[nidx] <= 1'b1;
            oid_mem[nidx]    <= id_reg;
        end
        else if (cmd.up_fin && is_remove)
        begin
            ovalid_mem[leaf_reg] <= 1'b0;
            oid_mem[leaf_reg]    <= '0;
        end
    end

    // Entry-to-leaf memory; presence lives in evalid_reg.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            eq_leaf <= eleaf_mem[s_tdata[wsts_pkg::ID_W-1:0]];
        end
        if (cmd.ins_fin)
        begin
            eleaf_mem[id_reg] <= nidx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg <= wsts_pkg::kind_t'(s_tuser);
            id_reg   <= s_tdata[7:0];
            w_reg    <= s_tdata[31:8];
            draw_reg <= s_tdata[79:32];
        end
        if (cmd.decide)
        begin
            node_reg   <= NW'(1);
            res_id_reg <= id_reg;
            leaf_reg   <= eq_leaf;
            case (kind_reg)
                wsts_pkg::K_INSERT:
                begin
                    res_status_reg <= id_valid ? wsts_pkg::ST_DUP : wsts_pkg::ST_FULL;
                    res_leaf_reg   <= id_valid ? eq_leaf : '0;
                end
                wsts_pkg::K_REMOVE,
                wsts_pkg::K_UPDATE:
                begin
                    res_status_reg <= wsts_pkg::ST_ABSENT;
                    res_leaf_reg   <= '0;
                    node_reg       <= {1'b1, eq_leaf};
                end
                default:
                begin
                    res_status_reg <= wsts_pkg::ST_EMPTY;
                    res_id_reg     <= '0;
                    res_leaf_reg   <= '0;
                end
            endcase
        end
        if (cmd.ins_wr)
        begin
            node_reg <= {node_reg[NW-2:0], !(tq_lc <= tq_rc)};
        end
        if (cmd.ins_fin)
        begin
            res_status_reg <= wsts_pkg::ST_OK;
            res_leaf_reg   <= nidx;
        end
        if (cmd.up_old)
        begin
            old_reg <= wq;
        end
        if (cmd.up_wr)
        begin
            node_reg <= {1'b0, node_reg[NW-1:1]};
        end
        if (cmd.up_fin)
        begin
            res_status_reg <= wsts_pkg::ST_OK;
            res_leaf_reg   <= leaf_reg;
        end
        if (cmd.sel_mul)
        begin
            prod_reg <= wsts_pkg::PROD_W'(tq_sum) * wsts_pkg::PROD_W'(rate_reg);
        end
        if (cmd.sel_cmp)
        begin
            if (draw_reg <= prod_reg)
            begin
                node_reg <= {node_reg[NW-2:0], 1'b0};
            end
            else
            begin
                draw_reg <= draw_reg - prod_reg;
                node_reg <= {node_reg[NW-2:0], 1'b1};
            end
        end
        if (cmd.sel_fin)
        begin
            res_leaf_reg   <= nidx;
            res_status_reg <= oq_valid ? wsts_pkg::ST_OK : wsts_pkg::ST_ABSENT;
            res_id_reg     <= oq_valid ? oq_id : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            evalid_reg  <= '0;
            total_reg   <= '0;
            count_reg   <= '0;
            rate_reg    <= wsts_pkg::RATE_RESET;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + LVL'(1);
            end
            if (cfg_wr)
            begin
                rate_reg <= pwdata[wsts_pkg::RATE_W-1:0];
            end
            if (cmd.ins_fin)
            begin
                evalid_reg[id_reg] <= 1'b1;
                total_reg          <= total_reg + wsts_pkg::SUM_W'(w_reg);
                count_reg          <= count_reg + CW'(1);
            end
            if (cmd.up_old)
            begin
                if (is_remove)
                begin
                    total_reg <= (count_reg <= CW'(1)) ? '0
                                 : total_reg - wsts_pkg::SUM_W'(wq);
                end
                else
                begin
                    total_reg <= total_reg - wsts_pkg::SUM_W'(wq) + wsts_pkg::SUM_W'(w_reg);
                end
            end
            if (cmd.up_fin && is_remove)
            begin
                evalid_reg[id_reg] <= 1'b0;
                if (!tree_empty)
                begin
                    count_reg <= count_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {5'd0, total_reg, 8'(res_leaf_reg), res_id_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign prdata   = (paddr == wsts_pkg::ADDR_BASE_RATE)
                      ? wsts_pkg::PDATA_W'(rate_reg) : '0;

endmodule

// ===== rtl/weighted_sum_tree_sampler_core.sv =====
// Top level of the weighted sum-tree sampler: sequencer plus datapath.
//
//   channel   direction  handshake                 payload
//   s_*       in         s_tvalid / s_tready       s_tdata, s_tuser (one operation)
//   m_*       out        m_tvalid / m_tready       m_tdata (one result)
//   apb       in         psel & penable & pwrite   base_rate at address 0
//
// An insert walks the tree down from the root, a remove or update walks up from its
// leaf and a select walks down from the root; a rejected item goes straight from the
// decide state to the result load. The sequencer passes through idle before the next item is taken; each tree
// level is a read and a write (or read, multiply, compare) of the node memory.
// After reset a clearing pass over every leaf index empties the node and owner memories;
// s_tready stays low until it ends. A result waits in the output register while the
// next item is taken; a second result stalls the sequencer until m_tready.
`include "weighted_sum_tree_sampler_core_assert.svh"

module weighted_sum_tree_sampler_core #(
    parameter int LEAVES = wsts_pkg::LEAVES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] entry_id, [31:8] weight, [79:32] draw_value
    input  logic [wsts_pkg::IN_W-1:0]     s_tdata,
    // [1:0] kind
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] status, [10:3] selected_id, [18:11] leaf_position, [50:19] total_weight
    output logic [wsts_pkg::OUT_W-1:0]    m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsts_pkg::PADDR_W-1:0]  paddr,
    input  logic [wsts_pkg::PDATA_W-1:0]  pwdata,
    output logic [wsts_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    wsts_pkg::cmd_t cmd;
    wsts_pkg::sts_t sts;

    assign pready = 1'b1;

    wsts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wsts_dp #(
        .LEAVES (LEAVES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .cmd      (cmd),
        .sts      (sts)
    );

    `WSTS_ASSERT_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready, "busy accept")
    `WSTS_ASSERT_SAME(a_out_space, clk, rst_n, cmd.out_load, !m_tvalid || m_tready, "lost result")
    `WSTS_ASSERT_SAME(a_clear_closed, clk, rst_n, cmd.clr_step, !s_tready, "accept in clear")

endmodule
